// File: rtl/core/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int NUM_FRAMES = 32768;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = NUM_FRAMES / WORD_BITS;
  localparam int WADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = 16;
  localparam int FRAME_W    = 15;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] MANAGED_RESET  = 16'd32512;
  localparam logic [CNT_W-1:0] RESERVED_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_MANAGED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;

  typedef enum logic [2:0] {
    FUNC_ALLOC_ONE = 3'd0,
    FUNC_FREE_ONE  = 3'd1,
    FUNC_ALLOC_RUN = 3'd2,
    FUNC_FREE_RUN  = 3'd3,
    FUNC_INIT      = 3'd4
  } func_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [FRAME_W-1:0] page_index;
    logic [CNT_W-1:0]   run_length;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame_index;
    logic [CNT_W-1:0]   used_pages;
  } rsp_t;

endpackage

// File: rtl/core/bpfa_req_if.sv
// ----------------------------------------------------------------------------
// bpfa_req_if
// Request channel: valid, ready and one operation.
// ----------------------------------------------------------------------------
interface bpfa_req_if;
  logic          valid;
  logic          ready;
  bpfa_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bpfa_rsp_if.sv
// ----------------------------------------------------------------------------
// bpfa_rsp_if
// Response channel: valid, ready and one result.
// ----------------------------------------------------------------------------
interface bpfa_rsp_if;
  logic          valid;
  logic          ready;
  bpfa_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a used-bit bitmap held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transaction (alloc one, free one, alloc
//   run, free run, init); rsp_o returns exactly one result per request.
//   cfg_we_i/cfg_idx_i/cfg_data_i write managed_pages and reserved_low_pages.
//   Write them only while the block is idle; the block does not enforce it.
// Steps (bitmap is 1024 words of 32 bits, read through a registered port):
//   alloc one : reads and checks one word after another from word 0.
//   free one  : one read-modify-write of the word that holds the frame.
//   alloc run : checks one frame at a time, reading each word once, then
//               marks the run with a read and a write per word.
//   free run  : a read and a write per word touched.
//   init      : one word written per cycle.
// One request is in flight at a time; the next is taken while the last
// result still waits in the output register. A stalled receiver holds the
// result and, once a second result is ready, the block.
// Reset: a clearing pass writes zero to all 1024 words with req_i not
// ready; the used count resets to zero.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bpfa_pkg::CNT_W-1:0]     cfg_data_i,
  bpfa_req_if.sink                       req_i,
  bpfa_rsp_if.source                     rsp_o
);
  import bpfa_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A1_RD, S_A1_CHK, S_RUN_RD, S_RUN_BIT,
    S_RNG_RD, S_RNG_WR, S_INIT_WR, S_DONE
  } state_e;

  state_e               state_q;
  logic [WADDR_W-1:0]   w_q;
  logic [CNT_W-1:0]     i_q, run_q, len_q, lo_q, hi_q;
  logic                 set_q;
  logic                 res_ok_q;
  logic [FRAME_W-1:0]   res_frame_q;
  logic [CNT_W-1:0]     cnt_q, managed_q, reserved_q;
  logic                 ov_q;
  rsp_t                 od_q;

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [WADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [CNT_W-1:0]     lim, rsv, wbase, fb, hlast, start;
  logic [CNT_W:0]       fr_end;
  logic [WORD_BITS-1:0] in_rng, below_lim, below_r, free_v, rng_flip, new_word;
  logic [BIT_W-1:0]     first_b;
  logic                 found;
  logic [CNT_W-1:0]     n_flip;
  req_t                 rq;

  assign rq       = req_i.data;
  assign lim      = (managed_q > CNT_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : managed_q;
  assign rsv      = (reserved_q > lim) ? lim : reserved_q;
  assign wbase    = CNT_W'({w_q, BIT_W'(0)});
  assign hlast    = hi_q - 1'b1;
  assign fr_end   = {1'b0, CNT_W'(rq.page_index)} + {1'b0, rq.run_length};
  assign start    = i_q + 1'b1 - len_q;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      fb           = wbase + CNT_W'(b);
      in_rng[b]    = (fb >= lo_q) && (fb < hi_q);
      below_lim[b] = fb < lim;
      below_r[b]   = fb < rsv;
    end
    free_v  = ~rdata_q & below_lim;
    found   = |free_v;
    first_b = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_v[b]) first_b = BIT_W'(b);
    end
    rng_flip = set_q ? (~rdata_q & in_rng) : (rdata_q & in_rng);
    new_word = set_q ? (rdata_q | in_rng) : (rdata_q & ~in_rng);
    n_flip   = CNT_W'($countones(rng_flip));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = w_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = w_q;
    unique case (state_q)
      S_CLR:     mem_we = 1'b1;
      S_INIT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = below_r;
      end
      S_A1_CHK: begin
        mem_we    = found;
        mem_wdata = rdata_q | (WORD_BITS'(1) << first_b);
      end
      S_RNG_WR: begin
        mem_we    = 1'b1;
        mem_wdata = new_word;
      end
      S_A1_RD, S_RNG_RD: mem_re = 1'b1;
      S_RUN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q[BIT_W +: WADDR_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      w_q         <= '0;
      cnt_q       <= '0;
      managed_q   <= MANAGED_RESET;
      reserved_q  <= RESERVED_RESET;
      ov_q        <= 1'b0;
      i_q         <= '0;
      run_q       <= '0;
      len_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      set_q       <= 1'b0;
      res_ok_q    <= 1'b0;
      res_frame_q <= '0;
      od_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MANAGED:  managed_q  <= cfg_data_i;
          CFG_RESERVED: reserved_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_o.ready) ov_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          w_q <= w_q + 1'b1;
          if (w_q == WADDR_W'(MAP_WORDS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_i.valid) begin
            res_ok_q    <= 1'b0;
            res_frame_q <= '0;
            state_q     <= S_DONE;
            len_q       <= rq.run_length;
            case (rq.func)
              FUNC_ALLOC_ONE: begin
                w_q <= '0;
                if (lim != '0) state_q <= S_A1_RD;
              end
              FUNC_FREE_ONE: begin
                if (CNT_W'(rq.page_index) < lim) begin
                  lo_q     <= CNT_W'(rq.page_index);
                  hi_q     <= CNT_W'(rq.page_index) + 1'b1;
                  set_q    <= 1'b0;
                  w_q      <= rq.page_index[BIT_W +: WADDR_W];
                  res_ok_q <= 1'b1;
                  state_q  <= S_RNG_RD;
                end
              end
              FUNC_ALLOC_RUN: begin
                if (rq.run_length != '0 && rq.run_length <= lim) begin
                  i_q     <= '0;
                  run_q   <= '0;
                  state_q <= S_RUN_RD;
                end
              end
              FUNC_FREE_RUN: begin
                if (rq.run_length != '0 && fr_end <= {1'b0, lim}) begin
                  lo_q     <= CNT_W'(rq.page_index);
                  hi_q     <= fr_end[CNT_W-1:0];
                  set_q    <= 1'b0;
                  w_q      <= rq.page_index[BIT_W +: WADDR_W];
                  res_ok_q <= 1'b1;
                  state_q  <= S_RNG_RD;
                end
              end
              FUNC_INIT: begin
                w_q      <= '0;
                cnt_q    <= rsv;
                res_ok_q <= 1'b1;
                state_q  <= S_INIT_WR;
              end
              default: ;
            endcase
          end
        end
        S_A1_RD: state_q <= S_A1_CHK;
        S_A1_CHK: begin
          if (found) begin
            cnt_q       <= cnt_q + 1'b1;
            res_ok_q    <= 1'b1;
            res_frame_q <= FRAME_W'(wbase) | FRAME_W'(first_b);
            state_q     <= S_DONE;
          end else if ({1'b0, wbase} + (CNT_W + 1)'(WORD_BITS) >= {1'b0, lim}) begin
            state_q <= S_DONE;
          end else begin
            w_q     <= w_q + 1'b1;
            state_q <= S_A1_RD;
          end
        end
        S_RUN_RD: state_q <= S_RUN_BIT;
        S_RUN_BIT: begin
          if (i_q >= lim) begin
            state_q <= S_DONE;
          end else if (!rdata_q[i_q[BIT_W-1:0]] && (run_q + 1'b1 == len_q)) begin
            lo_q        <= start;
            hi_q        <= i_q + 1'b1;
            set_q       <= 1'b1;
            w_q         <= start[BIT_W +: WADDR_W];
            res_ok_q    <= 1'b1;
            res_frame_q <= FRAME_W'(start);
            state_q     <= S_RNG_RD;
          end else begin
            run_q <= rdata_q[i_q[BIT_W-1:0]] ? '0 : run_q + 1'b1;
            i_q   <= i_q + 1'b1;
            if (i_q[BIT_W-1:0] == {BIT_W{1'b1}}) state_q <= S_RUN_RD;
          end
        end
        S_RNG_RD: state_q <= S_RNG_WR;
        S_RNG_WR: begin
          cnt_q <= set_q ? cnt_q + n_flip : cnt_q - n_flip;
          if (hlast[BIT_W +: WADDR_W] == w_q) begin
            state_q <= S_DONE;
          end else begin
            w_q     <= w_q + 1'b1;
            state_q <= S_RNG_RD;
          end
        end
        S_INIT_WR: begin
          w_q <= w_q + 1'b1;
          if (w_q == WADDR_W'(MAP_WORDS - 1)) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!ov_q || rsp_o.ready) begin
            ov_q             <= 1'b1;
            od_q.ok          <= res_ok_q;
            od_q.frame_index <= res_frame_q;
            od_q.used_pages  <= cnt_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = ov_q;
  assign rsp_o.data  = od_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_FRAMES))
    else $error("used count above frame total");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside done state");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE) && (state_q != S_DONE))
    else $error("bitmap written while idle");

  a_fail_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ok_q) |-> (res_frame_q == '0))
    else $error("failed result carries a frame");
`endif

endmodule
